### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the box table rtl
// clk and rst are taken from the module that uses the macro
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define AB_CHECK(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// consequent holds in the same cycle as the antecedent
`define AB_CHECK_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define AB_CHECK_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// types, constants and helpers of the box push-out and point hit table
// ----------------------------------------------------------------------------
package aabb_pkg;

  // table size and derived widths
  localparam int MAX_BOXES = 4;
  localparam int IDX_W     = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CNT_W     = $clog2(MAX_BOXES + 1);
  // compare width for box_index against the fill count (count reaches 4 at most)
  localparam int SEL_W     = 5;

  // point positions during a walk: 16 bit inputs plus pushes of up to 5118
  localparam int POS_W = 20;

  // command queue between front and back, depth a power of two
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // opcodes of an input word
  localparam logic [2:0] OP_CLEAR  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_RETIRE = 3'd2;
  localparam logic [2:0] OP_PUSH   = 3'd3;
  localparam logic [2:0] OP_POINT  = 3'd4;

  // command kinds after classification
  localparam logic [2:0] K_NOP    = 3'd0;
  localparam logic [2:0] K_CLEAR  = 3'd1;
  localparam logic [2:0] K_APPEND = 3'd2;
  localparam logic [2:0] K_RETIRE = 3'd3;
  localparam logic [2:0] K_PUSH   = 3'd4;
  localparam logic [2:0] K_POINT  = 3'd5;

  // configuration register indexes, byte address is four times the index
  localparam logic [1:0] REG_AREA   = 2'd0;
  localparam logic [1:0] REG_FLOOR  = 2'd1;
  localparam logic [1:0] REG_MARGIN = 2'd2;
  localparam logic [1:0] REG_SOLID  = 2'd3;

  // configuration reset values
  localparam logic [9:0]  MARGIN_RST = 10'd30;
  localparam logic [11:0] SOLID_RST  = 12'd507;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [1:0]         box_index;
    logic [5:0]         box_area;
    logic signed [15:0] box_min_x;
    logic signed [15:0] box_max_x;
    logic signed [15:0] box_min_z;
    logic signed [15:0] box_max_z;
    logic signed [15:0] box_base_y;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic [11:0]        extent;
  } in_t;

  typedef struct packed {
    logic signed [15:0] new_x;
    logic signed [15:0] new_z;
    logic               point_solid;
    logic               any_active;
    logic               append_rejected;
  } out_t;

  typedef struct packed {
    logic [2:0] kind;
    in_t        item;
  } cmd_t;

  typedef struct packed {
    logic [5:0]         active_area;
    logic signed [15:0] floor_level;
    logic [9:0]         push_margin;
    logic [11:0]        solid_height;
  } cfg_t;

  typedef struct packed {
    logic [5:0]         area;
    logic               live;
    logic signed [15:0] lo_x;
    logic signed [15:0] hi_x;
    logic signed [15:0] lo_z;
    logic signed [15:0] hi_z;
    logic signed [15:0] base;
  } entry_t;

  function automatic logic [2:0] kind_of(input logic [2:0] opcode);
    logic [2:0] k;
    unique case (opcode)
      OP_CLEAR:  k = K_CLEAR;
      OP_APPEND: k = K_APPEND;
      OP_RETIRE: k = K_RETIRE;
      OP_PUSH:   k = K_PUSH;
      OP_POINT:  k = K_POINT;
      default:   k = K_NOP;
    endcase
    return k;
  endfunction

  function automatic logic signed [POS_W-1:0] wide16(input logic signed [15:0] v);
    return {{(POS_W - 16){v[15]}}, v};
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [POS_W-1:0] v);
    logic signed [15:0] r;
    if (v > wide16(16'sh7fff)) begin
      r = 16'sh7fff;
    end else if (v < wide16(16'sh8000)) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### sv/aabb_front.sv
// ----------------------------------------------------------------------------
// aabb_front
// takes input words, classifies the opcode and hands commands to the queue
// ----------------------------------------------------------------------------
module aabb_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  aabb_pkg::in_t    item,
  input  logic             q_full,
  output logic             q_push,
  output aabb_pkg::cmd_t   q_data
);

  logic           held;
  logic           held_next;
  logic           accept;
  aabb_pkg::cmd_t cmd;

  // one holding stage, stalls only while the queue is full
  assign busy      = held && q_full;
  assign accept    = start && !busy;
  assign q_push    = held && !q_full;
  assign q_data    = cmd;
  assign held_next = accept || (held && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.kind <= aabb_pkg::kind_of(item.opcode);
      cmd.item <= item;
    end
  end

endmodule

### sv/aabb_fifo.sv
// ----------------------------------------------------------------------------
// aabb_fifo
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  aabb_pkg::cmd_t wr_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output aabb_pkg::cmd_t rd_data
);

  aabb_pkg::cmd_t                 slots [aabb_pkg::Q_DEPTH];
  logic [aabb_pkg::Q_PTR_W-1:0]   wr_ptr;
  logic [aabb_pkg::Q_PTR_W-1:0]   rd_ptr;
  logic [aabb_pkg::Q_CNT_W-1:0]   count;

  assign full    = count == aabb_pkg::Q_CNT_W'(aabb_pkg::Q_DEPTH);
  assign empty   = count == '0;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `AB_CHECK_IMPL(a_no_overrun, push, !full, "command queue written while full")

endmodule

### sv/aabb_back.sv
// ----------------------------------------------------------------------------
// aabb_back
// owns the box table, applies table commands and walks the boxes for queries
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aabb_back (
  input  logic           clk,
  input  logic           rst,
  input  aabb_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  aabb_pkg::cmd_t q_data,
  output logic           q_pop,
  output logic           done,
  output aabb_pkg::out_t result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]                     state;
  logic [1:0]                     state_next;
  aabb_pkg::cmd_t                 cmd;
  logic [aabb_pkg::IDX_W-1:0]     idx;
  logic [aabb_pkg::CNT_W-1:0]     entry_count;
  aabb_pkg::entry_t               boxes [aabb_pkg::MAX_BOXES];
  logic signed [aabb_pkg::POS_W-1:0] px;
  logic signed [aabb_pkg::POS_W-1:0] pz;
  logic                           solid;
  logic                           rejected;

  logic                           is_query;
  logic                           last;
  logic                           has_room;
  logic                           retire_ok;
  aabb_pkg::entry_t               ent;
  logic                           takes;
  logic                           any_active;

  logic signed [aabb_pkg::POS_W-1:0] grow;
  logic signed [aabb_pkg::POS_W-1:0] ext_w;
  logic signed [aabb_pkg::POS_W-1:0] lx, hx, lz, hz;
  logic signed [aabb_pkg::POS_W-1:0] pl, pr, pf, pb;
  logic signed [aabb_pkg::POS_W-1:0] best;
  logic signed [aabb_pkg::POS_W-1:0] push_x, push_z;
  logic                           in_box;
  logic signed [aabb_pkg::POS_W-1:0] py;
  logic signed [aabb_pkg::POS_W-1:0] base, bot;
  logic                           hit;

  assign is_query  = (cmd.kind == aabb_pkg::K_PUSH) || (cmd.kind == aabb_pkg::K_POINT);
  assign last      = idx == aabb_pkg::IDX_W'(aabb_pkg::MAX_BOXES - 1);
  assign has_room  = entry_count < aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES);
  assign retire_ok = aabb_pkg::SEL_W'(cmd.item.box_index) < aabb_pkg::SEL_W'(entry_count);
  assign q_pop     = !q_empty && ((state == S_IDLE) || (state == S_FIN));

  // entry under the walk
  assign ent   = boxes[idx];
  assign takes = (aabb_pkg::CNT_W'(idx) < entry_count) && ent.live &&
                 (ent.area == cfg.active_area);

  // push-out against the grown box
  assign grow  = aabb_pkg::POS_W'(cmd.item.extent) + aabb_pkg::POS_W'(cfg.push_margin);
  assign lx    = aabb_pkg::wide16(ent.lo_x) - grow;
  assign hx    = aabb_pkg::wide16(ent.hi_x) + grow;
  assign lz    = aabb_pkg::wide16(ent.lo_z) - grow;
  assign hz    = aabb_pkg::wide16(ent.hi_z) + grow;
  assign in_box = (px > lx) && (px < hx) && (pz > lz) && (pz < hz);
  assign pl    = px - lx;
  assign pr    = hx - px;
  assign pf    = pz - lz;
  assign pb    = hz - pz;

  // least penetrated side, ties keep the earlier side
  always_comb begin
    best   = pl;
    push_x = lx;
    push_z = pz;
    if (pr < best) begin
      best   = pr;
      push_x = hx;
      push_z = pz;
    end
    if (pf < best) begin
      best   = pf;
      push_x = px;
      push_z = lz;
    end
    if (pb < best) begin
      push_x = px;
      push_z = hz;
    end
  end

  // point test against the widened box and height span
  assign ext_w = aabb_pkg::POS_W'(cmd.item.extent);
  assign py    = aabb_pkg::wide16(cmd.item.point_y);
  assign base  = aabb_pkg::wide16(ent.base) + aabb_pkg::wide16(cfg.floor_level);
  assign bot   = base - aabb_pkg::POS_W'(cfg.solid_height);
  assign hit   = takes && (py >= bot) && (py <= base) &&
                 (px >= aabb_pkg::wide16(ent.lo_x) - ext_w) &&
                 (px <= aabb_pkg::wide16(ent.hi_x) + ext_w) &&
                 (pz >= aabb_pkg::wide16(ent.lo_z) - ext_w) &&
                 (pz <= aabb_pkg::wide16(ent.hi_z) + ext_w);

  always_comb begin
    any_active = 1'b0;
    for (int i = 0; i < aabb_pkg::MAX_BOXES; i++) begin
      if ((aabb_pkg::CNT_W'(i) < entry_count) && boxes[i].live &&
          (boxes[i].area == cfg.active_area)) begin
        any_active = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (state)
      S_IDLE:  state_next = q_pop ? S_WALK : S_IDLE;
      S_WALK:  state_next = (is_query && !last) ? S_WALK : S_FIN;
      S_FIN:   state_next = q_pop ? S_WALK : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == S_FIN;
      if (state == S_WALK) begin
        if (cmd.kind == aabb_pkg::K_CLEAR) begin
          entry_count <= '0;
        end else if ((cmd.kind == aabb_pkg::K_APPEND) && has_room) begin
          entry_count <= entry_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd      <= q_data;
      idx      <= '0;
      px       <= aabb_pkg::wide16(q_data.item.point_x);
      pz       <= aabb_pkg::wide16(q_data.item.point_z);
      solid    <= 1'b0;
      rejected <= 1'b0;
    end else if (state == S_WALK) begin
      idx <= idx + 1'b1;
      if ((cmd.kind == aabb_pkg::K_PUSH) && takes && in_box) begin
        px <= push_x;
        pz <= push_z;
      end
      if ((cmd.kind == aabb_pkg::K_POINT) && hit) begin
        solid <= 1'b1;
      end
      if (cmd.kind == aabb_pkg::K_APPEND) begin
        rejected <= !has_room;
        if (has_room) begin
          boxes[entry_count[aabb_pkg::IDX_W-1:0]] <= '{
            area: cmd.item.box_area,
            live: 1'b1,
            lo_x: cmd.item.box_min_x,
            hi_x: cmd.item.box_max_x,
            lo_z: cmd.item.box_min_z,
            hi_z: cmd.item.box_max_z,
            base: cmd.item.box_base_y
          };
        end
      end
      if ((cmd.kind == aabb_pkg::K_RETIRE) && retire_ok) begin
        boxes[aabb_pkg::IDX_W'(cmd.item.box_index)].live <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      result.new_x           <= aabb_pkg::sat16(px);
      result.new_z           <= aabb_pkg::sat16(pz);
      result.point_solid     <= solid;
      result.any_active      <= any_active;
      result.append_rejected <= rejected;
    end
  end

  `AB_CHECK(a_count_bound, entry_count <= aabb_pkg::CNT_W'(aabb_pkg::MAX_BOXES),
            "fill count past table size")
  `AB_CHECK_NEXT(a_fin_strobes, state == S_FIN, done, "finished command gave no result strobe")
  `AB_CHECK_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `AB_CHECK_NEXT(a_table_op_short, (state == S_WALK) && !is_query, state == S_FIN,
                 "table command stayed in walk")

endmodule

### sv/aabb_pushout_and_point_hit_table.sv
// ----------------------------------------------------------------------------
// aabb_pushout_and_point_hit_table
// box table with sequential push-out and point-solid queries, apb config
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; every word yields exactly
// one result, shown on result for the single cycle in which done is high, and
// the receiver has to take it then since there is no way to hold it off. Words
// pass a one-word front stage and a two-entry queue, so busy only rises once
// both are full. The back end takes one command from the queue at a time:
// clear, append, retire and unused opcodes pass the walk state once and then
// the finish state, while a push-out or point query stays in the walk state
// for every table slot before finishing, since the single push/compare unit
// visits one table entry per cycle in table order and each push moves the
// point that the next entry sees.
// Configuration writes are meant for an idle block.
module aabb_pushout_and_point_hit_table (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  aabb_pkg::in_t  item,
  output logic           done,
  output aabb_pkg::out_t result,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  aabb_pkg::cfg_t cfg;
  logic           wr_en;

  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  aabb_pkg::cmd_t q_wr_data;
  aabb_pkg::cmd_t q_rd_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_area  <= '0;
      cfg.floor_level  <= '0;
      cfg.push_margin  <= aabb_pkg::MARGIN_RST;
      cfg.solid_height <= aabb_pkg::SOLID_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        aabb_pkg::REG_AREA:   cfg.active_area  <= pwdata[5:0];
        aabb_pkg::REG_FLOOR:  cfg.floor_level  <= pwdata[15:0];
        aabb_pkg::REG_MARGIN: cfg.push_margin  <= pwdata[9:0];
        aabb_pkg::REG_SOLID:  cfg.solid_height <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      aabb_pkg::REG_AREA:   prdata = {26'd0, cfg.active_area};
      aabb_pkg::REG_FLOOR:  prdata = {16'd0, cfg.floor_level};
      aabb_pkg::REG_MARGIN: prdata = {22'd0, cfg.push_margin};
      aabb_pkg::REG_SOLID:  prdata = {20'd0, cfg.solid_height};
    endcase
  end

  aabb_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  aabb_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_rd_data)
  );

  aabb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_data  (q_rd_data),
    .q_pop   (q_pop),
    .done    (done),
    .result  (result)
  );

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: box push-out and point hit table bench
// Drives command words through start/busy and APB config writes, predicts
// every result with a behavioral model of the box table and compares each
// done strobe field by field. Directed corner words come first, then random
// clear/append/retire/query episodes under several configurations and
// sender gap settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  aabb_pkg::in_t  item = '0;
  logic           done;
  aabb_pkg::out_t result;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [3:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  aabb_pushout_and_point_hit_table u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // model copy of the configuration
  logic [5:0]         cfg_area   = 6'd0;
  logic signed [15:0] cfg_floor  = 16'sd0;
  logic [9:0]         cfg_margin = aabb_pkg::MARGIN_RST;
  logic [11:0]        cfg_solid  = aabb_pkg::SOLID_RST;

  // model copy of the box table
  int                 box_count = 0;
  logic [5:0]         box_area [aabb_pkg::MAX_BOXES];
  bit                 box_live [aabb_pkg::MAX_BOXES];
  logic signed [15:0] box_lo_x [aabb_pkg::MAX_BOXES];
  logic signed [15:0] box_hi_x [aabb_pkg::MAX_BOXES];
  logic signed [15:0] box_lo_z [aabb_pkg::MAX_BOXES];
  logic signed [15:0] box_hi_z [aabb_pkg::MAX_BOXES];
  logic signed [15:0] box_base [aabb_pkg::MAX_BOXES];

  aabb_pkg::in_t  word_q[$];
  aabb_pkg::out_t answer_q[$];
  int   gap_pct = 0;
  int   n_queued = 0;
  int   n_taken = 0;
  int   n_err = 0;
  int   n_push = 0;
  int   n_point = 0;
  int   n_hits = 0;
  int   n_rejects = 0;
  bit   took = 1'b0;
  aabb_pkg::out_t want;

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rnd16();
    logic [31:0] r;
    r = $urandom;
    return r[15:0];
  endfunction

  function automatic bit box_counts(int i);
    return box_live[i] && box_area[i] == cfg_area;
  endfunction

  // apply one word to the model table and work out its result
  function automatic aabb_pkg::out_t table_step(aabb_pkg::in_t w);
    aabb_pkg::out_t r;
    int px, py, pz, ext, grow, lx, hx, lz, hz, pl, pr, pf, pb, best, dx, dz, base;
    bit hit, rej, any;
    px = int'(w.point_x);
    py = int'(w.point_y);
    pz = int'(w.point_z);
    ext = int'(w.extent);
    hit = 1'b0;
    rej = 1'b0;
    any = 1'b0;
    case (w.opcode)
      aabb_pkg::OP_CLEAR: box_count = 0;
      aabb_pkg::OP_APPEND: begin
        if (box_count >= aabb_pkg::MAX_BOXES) begin
          rej = 1'b1;
        end else begin
          box_area[box_count] = w.box_area;
          box_live[box_count] = 1'b1;
          box_lo_x[box_count] = w.box_min_x;
          box_hi_x[box_count] = w.box_max_x;
          box_lo_z[box_count] = w.box_min_z;
          box_hi_z[box_count] = w.box_max_z;
          box_base[box_count] = w.box_base_y;
          box_count++;
        end
      end
      aabb_pkg::OP_RETIRE: begin
        if (int'(w.box_index) < box_count) box_live[w.box_index] = 1'b0;
      end
      aabb_pkg::OP_PUSH: begin
        grow = ext + int'(cfg_margin);
        for (int i = 0; i < box_count; i++) begin
          if (box_counts(i)) begin
            lx = int'(box_lo_x[i]) - grow;
            hx = int'(box_hi_x[i]) + grow;
            lz = int'(box_lo_z[i]) - grow;
            hz = int'(box_hi_z[i]) + grow;
            if (px > lx && px < hx && pz > lz && pz < hz) begin
              pl = px - lx;
              pr = hx - px;
              pf = pz - lz;
              pb = hz - pz;
              // ties resolve left, right, front, back
              best = pl; dx = -pl; dz = 0;
              if (pr < best) begin best = pr; dx = pr; dz = 0; end
              if (pf < best) begin best = pf; dx = 0; dz = -pf; end
              if (pb < best) begin dx = 0; dz = pb; end
              px += dx;
              pz += dz;
            end
          end
        end
      end
      aabb_pkg::OP_POINT: begin
        for (int i = 0; i < box_count; i++) begin
          if (box_counts(i)) begin
            base = int'(box_base[i]) + int'(cfg_floor);
            if (py >= base - int'(cfg_solid) && py <= base &&
                px >= int'(box_lo_x[i]) - ext && px <= int'(box_hi_x[i]) + ext &&
                pz >= int'(box_lo_z[i]) - ext && pz <= int'(box_hi_z[i]) + ext)
              hit = 1'b1;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < box_count; i++)
      if (box_counts(i)) any = 1'b1;
    r.new_x = clip16(px);
    r.new_z = clip16(pz);
    r.point_solid = hit;
    r.any_active = any;
    r.append_rejected = rej;
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      n_err++;
      if (n_err <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $realtime, name, exp_v, got_v);
    end
  endtask

  // driver: next word goes out at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (word_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
        item <= word_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on acceptance, compare on done
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        took = 1'b1;
        n_taken++;
        want = table_step(item);
        answer_q.push_back(want);
        if (item.opcode == aabb_pkg::OP_PUSH) n_push++;
        if (item.opcode == aabb_pkg::OP_POINT) n_point++;
        if (want.point_solid) n_hits++;
        if (want.append_rejected) n_rejects++;
      end
      if (done) begin
        if (answer_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("%0t: result word with nothing pending", $realtime);
        end else begin
          want = answer_q.pop_front();
          check_field("new_x", want.new_x, result.new_x);
          check_field("new_z", want.new_z, result.new_z);
          check_field("point_solid", 16'(want.point_solid), 16'(result.point_solid));
          check_field("any_active", 16'(want.any_active), 16'(result.any_active));
          check_field("append_rejected", 16'(want.append_rejected),
                      16'(result.append_rejected));
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    logic [31:0] exp_rd;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      aabb_pkg::REG_AREA: begin
        cfg_area = val[5:0];
        exp_rd = {26'd0, val[5:0]};
      end
      aabb_pkg::REG_FLOOR: begin
        cfg_floor = val[15:0];
        exp_rd = {16'd0, val[15:0]};
      end
      aabb_pkg::REG_MARGIN: begin
        cfg_margin = val[9:0];
        exp_rd = {22'd0, val[9:0]};
      end
      aabb_pkg::REG_SOLID: begin
        cfg_solid = val[11:0];
        exp_rd = {20'd0, val[11:0]};
      end
      default: exp_rd = '0;
    endcase
    // address still points at the register, so the read shows the new value
    if (prdata !== exp_rd || pready !== 1'b1) begin
      n_err++;
      if (n_err <= 10)
        $display("%0t: register %0d read %h, expected %h", $realtime, idx, prdata, exp_rd);
    end
  endtask

  task automatic set_config(logic [5:0] area, logic signed [15:0] floor_v,
                            logic [9:0] margin, logic [11:0] solid);
    write_reg(aabb_pkg::REG_AREA, 32'(area));
    write_reg(aabb_pkg::REG_FLOOR, 32'(floor_v));
    write_reg(aabb_pkg::REG_MARGIN, 32'(margin));
    write_reg(aabb_pkg::REG_SOLID, 32'(solid));
  endtask

  // hold off until every word is taken and answered, then let the pipe settle
  task automatic drain();
    while (n_taken != n_queued || answer_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic queue_word(aabb_pkg::in_t w);
    word_q.push_back(w);
    n_queued++;
  endtask

  function automatic aabb_pkg::in_t noise_word();
    aabb_pkg::in_t w;
    logic [31:0] r;
    r = $urandom;
    w.opcode = r[2:0];
    w.box_index = r[4:3];
    w.box_area = r[10:5];
    w.extent = r[22:11];
    w.box_min_x = rnd16();
    w.box_max_x = rnd16();
    w.box_min_z = rnd16();
    w.box_max_z = rnd16();
    w.box_base_y = rnd16();
    w.point_x = rnd16();
    w.point_y = rnd16();
    w.point_z = rnd16();
    return w;
  endfunction

  task automatic add_box(logic [5:0] area, int lx, int hx, int lz, int hz, int base);
    aabb_pkg::in_t w;
    w = noise_word();
    w.opcode = aabb_pkg::OP_APPEND;
    w.box_area = area;
    w.box_min_x = clip16(lx);
    w.box_max_x = clip16(hx);
    w.box_min_z = clip16(lz);
    w.box_max_z = clip16(hz);
    w.box_base_y = clip16(base);
    queue_word(w);
  endtask

  task automatic add_query(logic [2:0] op, int x, int y, int z, int ext);
    aabb_pkg::in_t w;
    w = noise_word();
    w.opcode = op;
    w.point_x = clip16(x);
    w.point_y = clip16(y);
    w.point_z = clip16(z);
    w.extent = ext[11:0];
    queue_word(w);
  endtask

  task automatic add_retire(logic [1:0] idx);
    aabb_pkg::in_t w;
    w = noise_word();
    w.opcode = aabb_pkg::OP_RETIRE;
    w.box_index = idx;
    queue_word(w);
  endtask

  // random coordinate from lo-pad-8 to hi+pad+8, either order of lo and hi
  function automatic int near(int a, int b, int pad);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if ($urandom_range(5) == 0) return ($urandom_range(1) != 0) ? lo - pad : hi + pad;
    return lo - pad - 8 + int'($urandom_range(0, hi - lo + 2 * pad + 16));
  endfunction

  // one episode: optional clear, a few boxes, an optional retire, queries, an optional noise word
  task automatic gen_episode();
    int nb, nq, j, ext, pad, span, t, lx, hx, lz, hz, base, y;
    int ep_lx[6], ep_hx[6], ep_lz[6], ep_hz[6], ep_base[6];
    aabb_pkg::in_t w;
    logic [31:0] r;
    if ($urandom_range(9) != 0) begin
      w = noise_word();
      w.opcode = aabb_pkg::OP_CLEAR;
      queue_word(w);
    end
    nb = $urandom_range(1, 5);
    for (int k = 0; k < nb; k++) begin
      span = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
      lx = int'(rnd16());
      hx = int'(clip16(lx + span));
      span = ($urandom_range(7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 3000);
      lz = int'(rnd16());
      hz = int'(clip16(lz + span));
      // occasionally inverted bounds
      if ($urandom_range(9) == 0) begin t = lx; lx = hx; hx = t; end
      if ($urandom_range(9) == 0) begin t = lz; lz = hz; hz = t; end
      base = ($urandom_range(3) == 0) ? int'(rnd16()) : $urandom_range(0, 2000) - 1000;
      r = $urandom;
      add_box(($urandom_range(4) == 0) ? r[5:0] : cfg_area, lx, hx, lz, hz, base);
      ep_lx[k] = lx; ep_hx[k] = hx; ep_lz[k] = lz; ep_hz[k] = hz; ep_base[k] = base;
    end
    if ($urandom_range(2) == 0) begin
      r = $urandom;
      add_retire(r[1:0]);
    end
    nq = $urandom_range(2, 8);
    for (int k = 0; k < nq; k++) begin
      j = $urandom_range(0, nb - 1);
      ext = ($urandom_range(5) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
      if ($urandom_range(4) < 3) begin
        pad = ext + int'(cfg_margin);
        add_query(aabb_pkg::OP_PUSH, near(ep_lx[j], ep_hx[j], pad), int'(rnd16()),
                  near(ep_lz[j], ep_hz[j], pad), ext);
      end else begin
        base = ep_base[j] + int'(cfg_floor);
        if ($urandom_range(5) == 0)
          y = int'(rnd16());
        else
          y = base + 10 - int'($urandom_range(0, int'(cfg_solid) + 20));
        add_query(aabb_pkg::OP_POINT, near(ep_lx[j], ep_hx[j], ext), y,
                  near(ep_lz[j], ep_hz[j], ext), ext);
      end
    end
    if ($urandom_range(2) == 0) queue_word(noise_word());
  endtask

  task automatic random_phase(int gap, int count);
    int target;
    drain();
    gap_pct = gap;
    target = n_queued + count;
    while (n_queued < target) gen_episode();
  endtask

  initial begin
    aabb_pkg::in_t w;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed words at reset configuration
    add_query(aabb_pkg::OP_POINT, 0, 0, 0, 0);
    add_box(6'd0, -100, 100, -50, 50, 0);
    add_box(6'd5, -100, 100, -50, 50, 0);
    add_query(aabb_pkg::OP_PUSH, 0, 0, 0, 10);
    add_query(aabb_pkg::OP_PUSH, -130, 0, 0, 10);
    add_query(aabb_pkg::OP_PUSH, 130, 0, 0, 10);
    add_query(aabb_pkg::OP_PUSH, 0, 0, 80, 10);
    add_box(6'd0, 990, 1010, -500, 500, 0);
    add_query(aabb_pkg::OP_PUSH, 1000, 0, 0, 0);
    add_query(aabb_pkg::OP_PUSH, -140, 0, 0, 10);
    add_query(aabb_pkg::OP_POINT, 0, -10, 0, 0);
    add_query(aabb_pkg::OP_POINT, 0, 1, 0, 0);
    add_query(aabb_pkg::OP_POINT, 110, -507, 0, 10);
    add_retire(2'd0);
    add_query(aabb_pkg::OP_PUSH, 0, 0, 0, 10);
    add_retire(2'd0);
    add_retire(2'd3);
    add_box(6'd0, 100, -100, 50, -50, 0);
    add_query(aabb_pkg::OP_POINT, 0, -1, 0, 4095);
    add_box(6'd0, 0, 10, 0, 10, 0);
    for (int k = 1; k <= 3; k++) begin
      w = noise_word();
      w.opcode = aabb_pkg::OP_POINT + 3'(k);
      queue_word(w);
    end
    w = noise_word();
    w.opcode = aabb_pkg::OP_CLEAR;
    queue_word(w);
    add_box(6'd0, 32000, 32767, -32768, 32767, -32768);
    add_box(6'd0, -32768, -32000, -32768, 32767, 32767);
    add_query(aabb_pkg::OP_PUSH, 32767, 0, 0, 4095);
    add_query(aabb_pkg::OP_PUSH, -32768, 0, 0, 4095);
    add_query(aabb_pkg::OP_POINT, -32768, -32768, -32768, 4095);
    add_query(aabb_pkg::OP_POINT, 32767, -32768, 0, 0);

    drain();
    set_config(6'd63, 16'sh7fff, 10'd1023, 12'd4095);
    random_phase(0, 100);
    drain();
    set_config(6'd0, 16'sh8000, 10'd0, 12'd0);
    random_phase(81, 100);
    drain();
    set_config(6'($urandom_range(0, 63)), rnd16(), 10'($urandom_range(0, 1023)),
               12'($urandom_range(0, 4095)));
    random_phase(0, 100);
    drain();
    set_config(6'($urandom_range(0, 63)), rnd16(), 10'($urandom_range(0, 1023)),
               12'($urandom_range(0, 4095)));
    random_phase(9, 100);
    drain();
    set_config(6'd0, 16'sd0, aabb_pkg::MARGIN_RST, aabb_pkg::SOLID_RST);
    random_phase(81, 100);
    drain();

    $display("covered %0d words: %0d push-outs, %0d point queries (%0d hits)",
             n_taken, n_push, n_point, n_hits);
    $display("%0d appends refused on a full table, %0d mismatches", n_rejects, n_err);
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/aabb_pkg.sv
sv/aabb_front.sv
sv/aabb_fifo.sv
sv/aabb_back.sv
sv/aabb_pushout_and_point_hit_table.sv
bench/tb_top.sv
